@@ design/drlv_pkg.sv @@
// shared constants and types for the dirty rectangle list validator
// no dependencies
`default_nettype none

package drlv_pkg;

    localparam int unsigned FRAME_WIDTH  = 220;
    localparam int unsigned FRAME_HEIGHT = 176;
    localparam int unsigned HDR_LEN      = 8;
    localparam int unsigned HDR_POS_W    = $clog2(HDR_LEN);

    localparam logic [HDR_POS_W-1:0] HDR_POS_LAST = HDR_POS_W'(HDR_LEN - 1);

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [31:0] len;
    } t_hdr;

endpackage

`default_nettype wire

@@ design/drlv_hdr_check.sv @@
// header checker: frame bounds, length and native alignment rules
// depends on drlv_pkg
`default_nettype none

module drlv_hdr_check
    import drlv_pkg::*;
(
    input  var t_hdr       i_hdr,
    input  wire            i_native_mode,
    input  wire [1:0]      i_data_offset,
    output logic           o_pass
);

    logic [8:0]  w_x_end;
    logic [8:0]  w_y_end;
    logic [15:0] w_area;
    logic [31:0] w_exp_len;
    logic        w_bad_base;
    logic        w_bad_native;

    always_comb begin
        w_x_end      = {1'b0, i_hdr.x} + {1'b0, i_hdr.w};
        w_y_end      = {1'b0, i_hdr.y} + {1'b0, i_hdr.h};
        w_area       = i_hdr.w * i_hdr.h;
        w_exp_len    = {15'd0, w_area, 1'b0};
        w_bad_base   = (i_hdr.w == 8'd0) || (i_hdr.h == 8'd0)
                    || (w_x_end > 9'(FRAME_WIDTH))
                    || (w_y_end > 9'(FRAME_HEIGHT))
                    || (i_hdr.len != w_exp_len);
        w_bad_native = i_native_mode
                    && (i_hdr.x[0] || i_hdr.w[0] || (i_data_offset != 2'd0));
        o_pass       = !(w_bad_base || w_bad_native);
    end

endmodule

`default_nettype wire

@@ design/dirty_rect_list_validator_unit.sv @@
// dirty rectangle list validator top level: input register, parse state, result register
// depends on drlv_pkg and drlv_hdr_check
//
//   channel   | direction | signals                         | content
//   s_axis    | in        | tvalid tready tdata[15:0] tlast | payload byte, rect total, last
//   m_axis    | out       | tvalid tready tdata[15:0]       | valid flag, rectangles checked
//   cfg       | in        | valid ready data[0]             | native mode
//
// one byte per cycle sustained, unless a last byte waits on a stalled output; a byte is parsed from the input register
// the result is loaded into the output register when the last byte is parsed
// header check (one 8x8 multiply and 32-bit compare) runs in the parse cycle
// a stalled output only holds the input register when it carries a last byte
// synchronous active-low reset clears all control state; native mode resets to 0
`default_nettype none

module dirty_rect_list_validator_unit
    import drlv_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,   // [7:0] payload_byte, [15:8] rect_total
    input  wire         i_s_axis_tlast,

    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [0] valid_res, [8:1] rects_checked, [15:9] zero

    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_data
);

    // input register
    logic                 r_in_vld;
    logic [7:0]           r_byte;
    logic [7:0]           r_total;
    logic                 r_last;

    // parse state
    logic                 r_native;
    logic                 r_in_payload;
    logic [7:0]           r_expected;
    logic [HDR_POS_W-1:0] r_hdr_pos;
    logic [7:0]           r_hdr [HDR_LEN-1];
    logic [31:0]          r_data_rem;
    logic                 r_in_data;
    logic [1:0]           r_off;
    logic [7:0]           r_rects;
    logic                 r_failed;

    // result register
    logic                 r_out_vld;
    logic                 r_out_ok;
    logic [7:0]           r_out_cnt;

    logic                 w_adv;
    logic                 w_first;
    logic [7:0]           w_exp;
    logic [HDR_POS_W-1:0] w_pos;
    logic [31:0]          w_dr;
    logic                 w_ind;
    logic [1:0]           w_off;
    logic [7:0]           w_rd;
    logic                 w_fl;
    logic                 w_hdr_wr;
    logic                 w_pass;
    t_hdr                 w_hdr;

    logic [HDR_POS_W-1:0] n_hdr_pos;
    logic [31:0]          n_data_rem;
    logic                 n_in_data;
    logic [1:0]           n_off;
    logic [7:0]           n_rects;
    logic                 n_failed;
    logic                 n_out_ok;

    assign w_adv           = r_in_vld && (!r_last || !r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || w_adv;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'd0, r_out_cnt, r_out_ok};

    assign w_hdr = '{x: r_hdr[0], y: r_hdr[1], w: r_hdr[2], h: r_hdr[3],
                     len: {r_byte, r_hdr[6], r_hdr[5], r_hdr[4]}};

    // payload offset after this byte, feeds the alignment check
    assign w_first = !r_in_payload;
    assign w_off   = w_first ? 2'd0 : r_off;
    assign n_off   = w_off + 2'd1;

    drlv_hdr_check u_hdr_check (
        .i_hdr         (w_hdr),
        .i_native_mode (r_native),
        .i_data_offset (n_off),
        .o_pass        (w_pass)
    );

    always_comb begin
        w_exp      = w_first ? r_total : r_expected;
        w_pos      = w_first ? '0 : r_hdr_pos;
        w_dr       = w_first ? 32'd0 : r_data_rem;
        w_ind      = w_first ? 1'b0 : r_in_data;
        w_rd       = w_first ? 8'd0 : r_rects;
        w_fl       = w_first ? 1'b0 : r_failed;

        n_hdr_pos  = w_pos;
        n_data_rem = w_dr;
        n_in_data  = w_ind;
        n_rects    = w_rd;
        n_failed   = w_fl;
        w_hdr_wr   = 1'b0;

        if (!w_fl) begin
            if (w_ind) begin
                n_data_rem = w_dr - 32'd1;
                if (n_data_rem == 32'd0) begin
                    n_in_data = 1'b0;
                end
            end else if (w_rd >= w_exp) begin
                n_failed = 1'b1;
            end else if (w_pos == HDR_POS_LAST) begin
                n_hdr_pos = '0;
                if (w_pass) begin
                    n_rects    = w_rd + 8'd1;
                    n_data_rem = w_hdr.len;
                    n_in_data  = 1'b1;
                end else begin
                    n_failed = 1'b1;
                end
            end else begin
                w_hdr_wr  = 1'b1;
                n_hdr_pos = w_pos + HDR_POS_W'(1);
            end
        end

        n_out_ok = !n_failed && !n_in_data && (n_hdr_pos == '0) && (n_rects == w_exp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_native     <= 1'b0;
            r_in_payload <= 1'b0;
            r_expected   <= 8'd0;
            r_hdr_pos    <= '0;
            r_data_rem   <= 32'd0;
            r_in_data    <= 1'b0;
            r_off        <= 2'd0;
            r_rects      <= 8'd0;
            r_failed     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_native <= i_cfg_data;
            end
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_in_payload <= !r_last;
                r_expected   <= w_exp;
                r_hdr_pos    <= n_hdr_pos;
                r_data_rem   <= n_data_rem;
                r_in_data    <= n_in_data;
                r_off        <= n_off;
                r_rects      <= n_rects;
                r_failed     <= n_failed;
            end
            if (w_adv && r_last) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_byte  <= i_s_axis_tdata[7:0];
            r_total <= i_s_axis_tdata[15:8];
            r_last  <= i_s_axis_tlast;
        end
        if (w_adv && w_hdr_wr) begin
            r_hdr[w_pos] <= r_byte;
        end
        if (w_adv && r_last) begin
            r_out_ok  <= n_out_ok;
            r_out_cnt <= n_rects;
        end
    end

    // header and pixel phases never overlap
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_data |-> (r_hdr_pos == '0))
        else $error("header position moved during pixel data");

    // pixel phase always has bytes left
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_data |-> (r_data_rem != 32'd0))
        else $error("pixel phase with zero bytes remaining");

    // accepted headers never exceed the expected count
    a_rect_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rects <= r_expected)
        else $error("rectangle count beyond expected total");

    // a result appears only after a last byte was parsed
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_adv && r_last))
        else $error("result without a last byte");

endmodule

`default_nettype wire
